[rtl/core/chash_pkg.sv]
// Package for the 64-bit content hash block: constants, the mix-command type
// and queue sizing. No dependencies.

package chash_pkg;

   localparam logic [63:0] SEED_WORD   = 64'h243f6a8885a308d3;
   localparam logic [63:0] MUL_IN      = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MUL_STEP    = 64'hc2b2ae3d27d4eb4f;
   localparam logic [63:0] ADD_STEP    = 64'h165667b19e3779f9;
   localparam logic [63:0] MUL_FINAL   = 64'hff51afd7ed558ccd;
   localparam int unsigned ROT_AMOUNT  = 27;
   localparam int unsigned FINAL_SHIFT = 33;
   localparam int unsigned LEN_SHIFT   = 56;

   localparam logic OP_VALUE  = 1'b0;
   localparam logic OP_STRING = 1'b1;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_PTR_W = 2;
   localparam int unsigned QUEUE_CNT_W = 3;

   // One mix step for the back end
   typedef struct packed {
      logic        restart;   // reload seed before this mix
      logic        emit;      // deliver a digest after this mix
      logic [63:0] word;      // word to mix
   } chash_cmd_type;

endpackage

[rtl/core/chash_if.sv]
// Handshake interfaces for the request and response channels of the
// content hash block. No dependencies.

interface chash_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic [63:0] data;
   logic [3:0]  valid_bytes;
   logic        last;
   logic        restart;

   modport source (output valid, output operation, output data, output valid_bytes,
                   output last, output restart, input ready);
   modport sink   (input valid, input operation, input data, input valid_bytes,
                   input last, input restart, output ready);
endinterface

interface chash_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest;

   modport source (output valid, output digest, input ready);
   modport sink   (input valid, input digest, output ready);
endinterface

[rtl/core/chash_front.sv]
// Front end: accepts request items, tracks the open string length and
// turns each item into one or two mix commands. Uses chash_pkg, chash_if.

module chash_front (
   input  logic                    clock,
   input  logic                    reset,
   chash_req_if.sink               req_if,
   output logic                    push_valid,
   output chash_pkg::chash_cmd_type push_cmd,
   input  logic                    push_ready
);

   logic [7:0]  len_ff, len_in;
   logic        second_ff, second_in;
   logic        accept;
   logic [7:0]  base_len;
   logic [7:0]  tail_len;
   logic [63:0] masked;

   assign req_if.ready = push_ready && !second_ff;
   assign accept       = req_if.valid && req_if.ready;
   assign base_len     = req_if.restart ? 8'd0 : len_ff;
   assign tail_len     = base_len + {5'd0, req_if.valid_bytes[2:0]};

   // keep only the bytes below valid_bytes
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         masked[i*8 +: 8] = (3'(i) < req_if.valid_bytes[2:0]) ? req_if.data[i*8 +: 8] : 8'd0;
      end
   end

   always_comb begin
      push_valid       = 1'b0;
      push_cmd.restart = req_if.restart;
      push_cmd.emit    = 1'b1;
      push_cmd.word    = req_if.data;
      len_in           = len_ff;
      second_in        = second_ff;
      if (second_ff) begin
         // closing zero tail after a full last chunk
         push_valid       = 1'b1;
         push_cmd.restart = 1'b0;
         push_cmd.word    = {len_ff, 56'd0};
         if (push_ready) begin
            len_in    = 8'd0;
            second_in = 1'b0;
         end
      end else begin
         push_valid = req_if.valid;
         if (req_if.operation == chash_pkg::OP_VALUE) begin
            len_in = base_len;
         end else if (!req_if.last) begin
            len_in = base_len + 8'd8;
         end else if (req_if.valid_bytes[3]) begin
            push_cmd.emit = 1'b0;
            len_in        = base_len + 8'd8;
            second_in     = 1'b1;
         end else begin
            push_cmd.word = {tail_len, masked[55:0]};
            len_in        = 8'd0;
         end
         if (!accept) begin
            len_in    = len_ff;
            second_in = second_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= 8'd0;
         second_ff <= 1'b0;
      end else begin
         len_ff    <= len_in;
         second_ff <= second_in;
      end
   end

endmodule

[rtl/core/chash_queue.sv]
// Short command queue between front and back end of the content hash block.
// Uses chash_pkg.

module chash_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   input  chash_pkg::chash_cmd_type push_cmd,
   output logic                     push_ready,
   output logic                     pop_valid,
   output chash_pkg::chash_cmd_type pop_cmd,
   input  logic                     pop_ready
);

   chash_pkg::chash_cmd_type entry_ff [chash_pkg::QUEUE_DEPTH];
   logic [chash_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [chash_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [chash_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign push_ready = count_ff != chash_pkg::QUEUE_CNT_W'(chash_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/core/chash_back.sv]
// Back end: runs each mix command through one shared 32x32 multiplier
// (three passes per 64-bit product) and finalizes digests. Uses chash_pkg, chash_if.

module chash_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   input  chash_pkg::chash_cmd_type cmd,
   output logic                     cmd_ready,
   chash_rsp_if.source              rsp_if
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MIN  = 2'd1;   // word * MUL_IN
   localparam logic [1:0] ST_MSTP = 2'd2;   // rotated hash * MUL_STEP + ADD_STEP
   localparam logic [1:0] ST_MFIN = 2'd3;   // finalize multiply

   localparam logic [1:0] PH_LOLO = 2'd0;
   localparam logic [1:0] PH_LOHI = 2'd1;
   localparam logic [1:0] PH_HILO = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [1:0]  phase_ff, phase_in;
   logic [63:0] hash_ff, hash_in;
   logic [63:0] opnd_ff, opnd_in;
   logic [63:0] acc_ff, acc_in;
   logic        emit_ff, emit_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] digest_ff, digest_in;

   logic [63:0] konst;
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;
   logic [63:0] acc_base, addend, acc_sum;
   logic [63:0] mixed, rotated;
   logic        out_free;

   assign cmd_ready     = state_ff == ST_IDLE;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.digest = digest_ff;
   assign out_free      = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      case (state_ff)
         ST_MIN:  konst = chash_pkg::MUL_IN;
         ST_MSTP: konst = chash_pkg::MUL_STEP;
         default: konst = chash_pkg::MUL_FINAL;
      endcase
   end

   // low 64 bits of opnd * konst: lo*lo, then both cross terms shifted by 32
   assign mul_a   = (phase_ff == PH_HILO) ? opnd_ff[63:32] : opnd_ff[31:0];
   assign mul_b   = (phase_ff == PH_LOHI) ? konst[63:32] : konst[31:0];
   assign prod    = mul_a * mul_b;
   assign addend  = (phase_ff == PH_LOLO) ? prod : {prod[31:0], 32'd0};
   assign acc_sum = acc_base + addend;

   always_comb begin
      if (phase_ff != PH_LOLO) begin
         acc_base = acc_ff;
      end else if (state_ff == ST_MSTP) begin
         acc_base = chash_pkg::ADD_STEP;
      end else begin
         acc_base = 64'd0;
      end
   end

   assign mixed   = hash_ff ^ acc_sum;
   assign rotated = {mixed[63-chash_pkg::ROT_AMOUNT:0],
                     mixed[63:64-chash_pkg::ROT_AMOUNT]};

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      hash_in      = hash_ff;
      opnd_in      = opnd_ff;
      acc_in       = acc_ff;
      emit_in      = emit_ff;
      digest_in    = digest_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               opnd_in  = cmd.word;
               hash_in  = cmd.restart ? chash_pkg::SEED_WORD : hash_ff;
               emit_in  = cmd.emit;
               phase_in = PH_LOLO;
               state_in = ST_MIN;
            end
         end
         ST_MIN, ST_MSTP: begin
            acc_in   = acc_sum;
            phase_in = phase_ff + 2'd1;
            if (phase_ff == PH_HILO) begin
               phase_in = PH_LOLO;
               if (state_ff == ST_MIN) begin
                  opnd_in  = rotated;
                  state_in = ST_MSTP;
               end else begin
                  hash_in  = acc_sum;
                  opnd_in  = acc_sum ^ (acc_sum >> chash_pkg::FINAL_SHIFT);
                  state_in = emit_ff ? ST_MFIN : ST_IDLE;
               end
            end
         end
         default: begin
            // finalize; hold the last pass while the output is still occupied
            if (phase_ff != PH_HILO) begin
               acc_in   = acc_sum;
               phase_in = phase_ff + 2'd1;
            end else if (out_free) begin
               digest_in    = acc_sum ^ (acc_sum >> chash_pkg::FINAL_SHIFT);
               rsp_valid_in = 1'b1;
               phase_in     = PH_LOLO;
               state_in     = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_LOLO;
         hash_ff      <= chash_pkg::SEED_WORD;
         emit_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         hash_ff      <= hash_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      opnd_ff   <= opnd_in;
      acc_ff    <= acc_in;
      digest_ff <= digest_in;
   end

endmodule

[rtl/core/content_hash_64_top.sv]
// Top level of the 64-bit multiply-xorshift content hash block.
// Depends on chash_pkg, chash_if, chash_front, chash_queue and chash_back.
//
// Usage:
//   req_if carries one item per handshake: a raw 64-bit value (operation 0)
//   or a chunk of up to eight little-endian string bytes (operation 1, with
//   valid_bytes and last). restart reloads the seed and clears the open
//   string length before the item is handled.
//   rsp_if returns exactly one digest per item, in order: the finalized form
//   (xorshift 33, multiply, xorshift 33) of the running hash after that item.
//   Values, full chunks and short closing chunks need one mix step; a closing
//   chunk with eight or more valid bytes needs two. Each 64-bit product goes
//   through one shared 32x32 multiplier in three passes, and a mix holds two
//   products, so that multiplier sets the sustained rate; the back end takes a
//   new command only once it has finished the last one.
//   The front end keeps accepting items into a four-entry command queue while
//   the back end works, so req_if.ready drops only when that queue is full or
//   while a closing chunk issues its second mix step.
//   If the receiver stalls, the digest is held on rsp_if and the back end
//   keeps mixing queued commands; it waits only when it has a new digest to
//   deliver and the output register is still occupied.
//   Reset (synchronous, active high) loads the seed, clears the string
//   length, empties the queue and drops rsp_if.valid.

module content_hash_64_top (
   input  logic        clock,
   input  logic        reset,
   chash_req_if.sink   req_if,
   chash_rsp_if.source rsp_if
);

   // front to queue
   logic                     push_valid;
   logic                     push_ready;
   chash_pkg::chash_cmd_type push_cmd;

   // queue to back
   logic                     pop_valid;
   logic                     pop_ready;
   chash_pkg::chash_cmd_type pop_cmd;

   // Classify items and split closing chunks into mix commands
   chash_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready)
   );

   // Decouple front and back so each may stall on its own
   chash_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd),
      .pop_ready  (pop_ready)
   );

   // Mix, finalize and hold the digest for the receiver
   chash_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd       (pop_cmd),
      .cmd_ready (pop_ready),
      .rsp_if    (rsp_if)
   );

endmodule

[verif/tb_content_hash_64_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for content_hash_64_top: a digest predictor in a scoreboard
// class, directed and random items with random idling on both channels.
// Depends on chash_pkg, chash_if and the RTL of the block.

typedef struct packed {
   logic        operation;
   logic [63:0] data;
   logic [3:0]  valid_bytes;
   logic        last;
   logic        restart;
} hash_item_type;

// Tracks the running hash and open string length, queues the digest each item
// should produce and compares delivered digests in order.
class digest_scoreboard;
   logic [63:0] hash_word;
   logic [7:0]  open_length;
   logic [63:0] digest_q[$];
   int unsigned mismatches;
   int unsigned checked;

   function new();
      hash_word   = chash_pkg::SEED_WORD;
      open_length = 8'd0;
      mismatches  = 0;
      checked     = 0;
   endfunction

   // One mix step: fold the scaled word in, rotate, multiply and add
   function void absorb(logic [63:0] w);
      logic [63:0] h;
      h = hash_word ^ (w * chash_pkg::MUL_IN);
      h = (h << chash_pkg::ROT_AMOUNT) | (h >> (64 - chash_pkg::ROT_AMOUNT));
      hash_word = h * chash_pkg::MUL_STEP + chash_pkg::ADD_STEP;
   endfunction

   function logic [63:0] finished(logic [63:0] x);
      x = x ^ (x >> chash_pkg::FINAL_SHIFT);
      x = x * chash_pkg::MUL_FINAL;
      x = x ^ (x >> chash_pkg::FINAL_SHIFT);
      return x;
   endfunction

   function void note_item(hash_item_type it);
      logic [63:0] tail;
      logic [63:0] keep;
      if (it.restart) begin
         hash_word   = chash_pkg::SEED_WORD;
         open_length = 8'd0;
      end
      if (it.operation == chash_pkg::OP_VALUE) begin
         absorb(it.data);
      end else if (!it.last) begin
         absorb(it.data);
         open_length = open_length + 8'd8;
      end else begin
         if (it.valid_bytes >= 4'd8) begin
            absorb(it.data);
            open_length = open_length + 8'd8;
            tail = 64'd0;
         end else begin
            keep = (it.valid_bytes == 4'd0) ? 64'd0 : ((64'd1 << (it.valid_bytes * 8)) - 64'd1);
            tail = it.data & keep;
            open_length = open_length + {4'd0, it.valid_bytes};
         end
         absorb(tail ^ ({56'd0, open_length} << chash_pkg::LEN_SHIFT));
         open_length = 8'd0;
      end
      digest_q.insert(digest_q.size(), finished(hash_word));
   endfunction

   function void check_digest(logic [63:0] actual);
      logic [63:0] want;
      if (digest_q.size() == 0) begin
         $error("digest %h delivered with no item outstanding", actual);
         mismatches++;
         return;
      end
      want = digest_q.pop_front();
      checked++;
      if (actual !== want) begin
         $error("digest mismatch: expected %h, actual %h", want, actual);
         mismatches++;
      end
   endfunction

   function int pending();
      return digest_q.size();
   endfunction
endclass

module tb_content_hash_64_top;

   localparam int unsigned ITEM_TARGET  = 450;
   localparam int unsigned IDLE_LIMIT   = 5000;  // cycles with no handshake on either side
   localparam int unsigned HOLD_CYCLES  = 300;   // long receiver hold-off
   localparam int unsigned DRAIN_CYCLES = 80;

   logic clock;
   logic reset;

   chash_req_if req_if ();
   chash_rsp_if rsp_if ();

   content_hash_64_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   digest_scoreboard digests;

   // Idling control shared between the sender, the receiver and the main flow
   bit quiet_tx;
   bit quiet_rx;
   bit hold_request;

   int unsigned n_items;
   int unsigned n_values;
   int unsigned n_strings;
   int unsigned longest_chunks;
   int unsigned idle_count;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Mostly back-to-back or short gaps, now and then a long one
   function automatic int unsigned idle_cycles(bit quiet);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Bias words towards the corners as well as plain random patterns
   function automatic logic [63:0] pick_word();
      case ($urandom_range(0, 9))
         0: begin
            return 64'd0;
         end
         1: begin
            return {64{1'b1}};
         end
         2: begin
            return 64'd1 << $urandom_range(0, 63);
         end
         default: begin
            return {$urandom, $urandom};
         end
      endcase
   endfunction

   function automatic hash_item_type make_item(logic op, logic [63:0] d, logic [3:0] nbytes,
                                               logic lst, logic rst);
      hash_item_type it;
      it.operation   = op;
      it.data        = d;
      it.valid_bytes = nbytes;
      it.last        = lst;
      it.restart     = rst;
      return it;
   endfunction

   // Present one item, hold it until the block takes it, then note it for prediction.
   // Valid stays high on return so a following item can go out back to back.
   task automatic offer(hash_item_type it);
      int unsigned gap;
      gap = idle_cycles(quiet_tx);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.operation   <= it.operation;
      req_if.data        <= it.data;
      req_if.valid_bytes <= it.valid_bytes;
      req_if.last        <= it.last;
      req_if.restart     <= it.restart;
      do @(posedge clock); while (!(req_if.valid === 1'b1 && req_if.ready === 1'b1));
      digests.note_item(it);
      n_items++;
      if (it.operation == chash_pkg::OP_VALUE) n_values++;
      else if (it.last) n_strings++;
   endtask

   // A well-formed string: some full chunks, then a closing chunk. Full chunks carry a
   // random byte count, which the block must ignore; now and then drop a value item
   // into the open string.
   task automatic send_string(int unsigned chunks, logic [3:0] tail_bytes, logic rst);
      for (int unsigned i = 0; i < chunks; i++) begin
         offer(make_item(chash_pkg::OP_STRING, pick_word(), 4'($urandom_range(0, 15)), 1'b0,
                         rst && i == 0));
         if ($urandom_range(0, 19) == 0)
            offer(make_item(chash_pkg::OP_VALUE, pick_word(), 4'($urandom_range(0, 15)), 1'b0,
                            1'b0));
      end
      offer(make_item(chash_pkg::OP_STRING, pick_word(), tail_bytes, 1'b1, rst && chunks == 0));
      if (chunks + 1 > longest_chunks) longest_chunks = chunks + 1;
   endtask

   // Receiver: check each accepted digest, then pick ready for the next cycle.
   // A hold-off request from the main flow keeps ready low for a long stretch.
   initial begin
      int unsigned stall;
      stall = 0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            digests.check_digest(rsp_if.digest);
         if (hold_request) begin
            hold_request = 1'b0;
            stall = HOLD_CYCLES;
         end
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            stall--;
         end else begin
            rsp_if.ready <= 1'b1;
            stall = idle_cycles(quiet_rx);
         end
         @(posedge clock);
      end
   end

   // Watchdog: count cycles with no handshake on either channel
   always @(posedge clock) begin
      if (reset !== 1'b0) begin
         idle_count = 0;
      end else if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
                   (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
         idle_count = 0;
      end else begin
         idle_count++;
         if (idle_count >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_count);
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Main flow: reset, directed items, random sequences, drain, verdict
   initial begin
      bit          pressure_done;
      int unsigned pressure_end;
      int unsigned roll;
      digests = new();
      pressure_done = 1'b0;
      pressure_end  = 0;
      quiet_tx      = 1'b0;
      quiet_rx      = 1'b0;
      hold_request  = 1'b0;
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.operation   <= chash_pkg::OP_VALUE;
      req_if.data        <= 64'd0;
      req_if.valid_bytes <= 4'd0;
      req_if.last        <= 1'b0;
      req_if.restart     <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Value extremes, and a restart on a value
      offer(make_item(chash_pkg::OP_VALUE, 64'd0, 4'd0, 1'b0, 1'b0));
      offer(make_item(chash_pkg::OP_VALUE, {64{1'b1}}, 4'd15, 1'b1, 1'b0));
      offer(make_item(chash_pkg::OP_VALUE, 64'h8000_0000_0000_0000, 4'd8, 1'b0, 1'b1));
      // Empty string
      offer(make_item(chash_pkg::OP_STRING, {64{1'b1}}, 4'd0, 1'b1, 1'b0));
      // Short closing chunks: junk above the byte count must be dropped
      offer(make_item(chash_pkg::OP_STRING, 64'hdead_beef_cafe_0041, 4'd1, 1'b1, 1'b0));
      offer(make_item(chash_pkg::OP_STRING, {64{1'b1}}, 4'd7, 1'b1, 1'b0));
      // Closing chunk of exactly eight bytes, then a byte count above eight
      offer(make_item(chash_pkg::OP_STRING, 64'h0123_4567_89ab_cdef, 4'd8, 1'b1, 1'b0));
      offer(make_item(chash_pkg::OP_STRING, {64{1'b1}}, 4'd15, 1'b1, 1'b0));
      // Two-chunk string; the full chunk's byte count is ignored
      offer(make_item(chash_pkg::OP_STRING, 64'h1122_3344_5566_7788, 4'd3, 1'b0, 1'b0));
      offer(make_item(chash_pkg::OP_STRING, 64'hffff_ffff_a5a5_5a5a, 4'd4, 1'b1, 1'b0));
      // Value inside an open string keeps the length
      offer(make_item(chash_pkg::OP_STRING, 64'hfedc_ba98_7654_3210, 4'd0, 1'b0, 1'b0));
      offer(make_item(chash_pkg::OP_VALUE, 64'h0000_0000_0000_0001, 4'd0, 1'b0, 1'b0));
      offer(make_item(chash_pkg::OP_STRING, 64'h0f0f_0f0f_0f0f_0f0f, 4'd5, 1'b1, 1'b0));
      // Restart in the middle of a string drops the open length
      offer(make_item(chash_pkg::OP_STRING, {64{1'b1}}, 4'd8, 1'b0, 1'b0));
      offer(make_item(chash_pkg::OP_STRING, 64'h0000_0000_0000_abcd, 4'd2, 1'b1, 1'b1));
      // Sixteen bytes closed by an empty chunk
      offer(make_item(chash_pkg::OP_STRING, 64'h5555_5555_5555_5555, 4'd8, 1'b0, 1'b0));
      offer(make_item(chash_pkg::OP_STRING, 64'haaaa_aaaa_aaaa_aaaa, 4'd9, 1'b0, 1'b0));
      offer(make_item(chash_pkg::OP_STRING, {64{1'b1}}, 4'd0, 1'b1, 1'b0));
      // Restarts on a value and on a closing chunk
      offer(make_item(chash_pkg::OP_VALUE, {64{1'b1}}, 4'd0, 1'b0, 1'b1));
      offer(make_item(chash_pkg::OP_STRING, 64'd0, 4'd0, 1'b0, 1'b0));
      offer(make_item(chash_pkg::OP_STRING, {64{1'b1}}, 4'd8, 1'b1, 1'b0));
      offer(make_item(chash_pkg::OP_STRING, 64'd0, 4'd8, 1'b1, 1'b1));

      // Random part: mostly well-formed strings and values, some raw noise
      while (n_items < ITEM_TARGET) begin
         // Hold the receiver off while the sender keeps pushing, to fill the block
         if (!pressure_done && n_items >= 150) begin
            pressure_done = 1'b1;
            pressure_end  = n_items + 40;
            quiet_tx      = 1'b1;
            hold_request  = 1'b1;
         end
         if (pressure_done && n_items >= pressure_end && n_items < 300) quiet_tx = 1'b0;
         // A stretch with no idling on either side
         if (n_items >= 300 && n_items < 340) begin
            quiet_tx = 1'b1;
            quiet_rx = 1'b1;
         end else if (n_items >= 340) begin
            quiet_tx = 1'b0;
            quiet_rx = 1'b0;
         end

         roll = $urandom_range(0, 99);
         if (roll < 30) begin
            offer(make_item(chash_pkg::OP_VALUE, pick_word(), 4'($urandom_range(0, 15)),
                            1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0));
         end else if (roll < 34) begin
            // Long string: length may wrap past 256 bytes
            send_string($urandom_range(30, 36), 4'($urandom_range(0, 8)),
                        1'($urandom_range(0, 1)));
         end else if (roll < 85) begin
            send_string($urandom_range(0, 3),
                        4'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                        : $urandom_range(0, 8)),
                        $urandom_range(0, 7) == 0);
         end else begin
            offer(make_item(1'($urandom_range(0, 1)), pick_word(), 4'($urandom_range(0, 15)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
         end
      end
      req_if.valid <= 1'b0;

      // Drain: let every digest out, then watch for strays
      quiet_rx = 1'b1;
      while (digests.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d items sent, %0d values, %0d strings closed, longest %0d chunks",
               n_items, n_values, n_strings, longest_chunks);
      $display("summary: %0d digests checked, %0d mismatches", digests.checked, digests.mismatches);
      if (digests.mismatches == 0 && digests.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
